FILE: rtl/core/brb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the circular byte buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DATA_W = 8;
  localparam int LEN_W  = 7;
  localparam int FILL_W = 11;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_DELETE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_DATA  = 2'd2
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_write;   // accept a write transaction and post its result
    logic take_single;  // accept a delete or empty request and post its result
    logic take_stream;  // accept a read or peek that returns bytes
    logic rd_issue;     // read the byte at the stream pointer
    logic load_byte;    // move the byte read into the output register
  } brb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_write;     // pending input transaction is a write
    logic stream;       // pending request returns at least one byte
    logic out_free;     // output register can take a result this cycle
    logic final_byte;   // byte in flight is the last of its request
  } brb_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/brb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/brb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_datapath
// Pointers, fill count, byte store and output register of the byte buffer.
// ----------------------------------------------------------------------------
module brb_datapath
  import brb_pkg::*;
#(
  parameter int DEPTH       = 1024,
  parameter int MAX_REQUEST = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire brb_cmd_t          cmd,
  output brb_status_t            status,
  input  wire logic [1:0]        in_action,
  input  wire logic [DATA_W-1:0] in_data_in,
  input  wire logic [LEN_W-1:0]  in_length,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      out_data_out,
  output logic                   out_data_valid,
  output logic [LEN_W-1:0]       out_done_count,
  output logic                   out_last,
  output logic [FILL_W-1:0]      out_fill_level
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = (CW > LEN_W) ? CW : LEN_W;
  localparam int SW = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam int FW = (CW > FILL_W) ? CW : FILL_W;

  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [LEN_W-1:0]  reqn_r, reqn_nxt;
  logic [FILL_W-1:0] fill_after_r, fill_after_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic              dvalid_r, dvalid_nxt;
  logic [LEN_W-1:0]  done_r, done_nxt;
  logic              last_r, last_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  action_t           action;
  logic [LEN_W-1:0]  req_sat;
  logic [NW-1:0]     req_w, cnt_w, n_w;
  logic [LEN_W-1:0]  n;
  logic [SW-1:0]     head_sum, head_wrap;
  logic              full;
  logic [FW-1:0]     fill_ext;
  logic [DATA_W-1:0] ram_rdata;
  logic              ram_we;

  always_comb begin
    action  = action_t'(in_action);
    req_sat = (in_length > LEN_W'(MAX_REQUEST)) ? LEN_W'(MAX_REQUEST) : in_length;
    req_w   = NW'(req_sat);
    cnt_w   = NW'(count_r);
    n_w     = (req_w < cnt_w) ? req_w : cnt_w;
    n       = n_w[LEN_W-1:0];
    full    = (count_r == CW'(DEPTH));
    // head + n stays below twice the depth, so one subtract wraps it
    head_sum  = SW'(head_r) + SW'(n);
    head_wrap = (head_sum >= SW'(DEPTH)) ? (head_sum - SW'(DEPTH)) : head_sum;
    ram_we    = cmd.take_write && !full;
  end

  always_comb begin
    status.is_write   = (action == ACT_WRITE);
    status.stream     = (action inside {ACT_READ, ACT_PEEK}) && (n != '0);
    status.out_free   = !out_valid_r || out_ready;
    status.final_byte = (rem_r == '0);
  end

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    rem_nxt        = rem_r;
    reqn_nxt       = reqn_r;
    fill_after_nxt = fill_after_r;
    data_nxt       = data_r;
    dvalid_nxt     = dvalid_r;
    done_nxt       = done_r;
    last_nxt       = last_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;

    if (cmd.take_write) begin
      if (!full) begin
        tail_nxt  = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
        count_nxt = count_r + 1'b1;
      end
    end
    if (cmd.take_single || (cmd.take_stream && action == ACT_READ)) begin
      head_nxt  = head_wrap[AW-1:0];
      count_nxt = count_r - CW'(n);
    end
    fill_ext = FW'(count_nxt);

    if (cmd.take_write || cmd.take_single) begin
      out_valid_nxt = 1'b1;
      data_nxt      = '0;
      dvalid_nxt    = 1'b0;
      done_nxt      = cmd.take_write ? LEN_W'(!full) : n;
      last_nxt      = 1'b1;
      fill_nxt      = fill_ext[FILL_W-1:0];
    end
    if (cmd.take_stream) begin
      ptr_nxt        = head_r;
      rem_nxt        = n;
      reqn_nxt       = n;
      fill_after_nxt = fill_ext[FILL_W-1:0];
    end
    if (cmd.rd_issue) begin
      ptr_nxt = (ptr_r == AW'(DEPTH - 1)) ? '0 : ptr_r + 1'b1;
      rem_nxt = rem_r - 1'b1;
    end
    if (cmd.load_byte) begin
      out_valid_nxt = 1'b1;
      data_nxt      = ram_rdata;
      dvalid_nxt    = 1'b1;
      done_nxt      = reqn_r;
      last_nxt      = (rem_r == '0);
      fill_nxt      = fill_after_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r        <= ptr_nxt;
    reqn_r       <= reqn_nxt;
    fill_after_r <= fill_after_nxt;
    data_r       <= data_nxt;
    dvalid_r     <= dvalid_nxt;
    done_r       <= done_nxt;
    last_r       <= last_nxt;
    fill_r       <= fill_nxt;
  end

  brb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (in_data_in),
    .re    (cmd.rd_issue),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_data_out   = data_r;
  assign out_data_valid = dvalid_r;
  assign out_done_count = done_r;
  assign out_last       = last_r;
  assign out_fill_level = fill_r;

endmodule

`default_nettype wire

FILE: rtl/core/brb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer for the byte buffer: accepts transactions and paces byte reads.
// ----------------------------------------------------------------------------
module brb_ctrl
  import brb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire brb_status_t status,
  output brb_cmd_t         cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    accept    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = status.out_free;
        accept   = in_valid && status.out_free;
        if (accept) begin
          if (status.is_write) begin
            cmd.take_write = 1'b1;
          end else if (status.stream) begin
            cmd.take_stream = 1'b1;
            state_nxt       = ST_ISSUE;
          end else begin
            cmd.take_single = 1'b1;
          end
        end
      end
      ST_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_DATA;
      end
      ST_DATA: begin
        // hold the byte in the RAM output until the result register frees up
        if (status.out_free) begin
          cmd.load_byte = 1'b1;
          state_nxt     = status.final_byte ? ST_IDLE : ST_ISSUE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/byte_ring_buffer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer_unit
// Circular byte FIFO with write, read, peek and delete requests.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one request per transaction:
// a byte write, or a read, peek or delete of up to MAX_REQUEST bytes.
// Result channel (out_valid/out_ready) carries one transaction per returned
// byte, or a single status transaction for writes, deletes and requests that
// find nothing to return. Every result carries the fill level after the
// request; the final one of a request has out_last set.
// Writes, deletes and empty requests post their result the cycle after
// acceptance, and with out_ready held high a new request is accepted every
// cycle.
// A read or peek returns its bytes one at a time, paced by the registered
// read port of the byte store feeding the single output register; the next
// request is accepted only once its last byte is loaded.
// Reset empties the buffer (head, tail and fill count to zero); the store
// itself is not cleared. When out_ready is low a pending result holds in
// the output register and the block stops accepting and loading bytes.
// ----------------------------------------------------------------------------
module byte_ring_buffer_unit
  import brb_pkg::*;
#(
  parameter int DEPTH       = 1024,
  parameter int MAX_REQUEST = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_action,
  input  wire logic [DATA_W-1:0] in_data_in,
  input  wire logic [LEN_W-1:0]  in_length,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      out_data_out,
  output logic                   out_data_valid,
  output logic [LEN_W-1:0]       out_done_count,
  output logic                   out_last,
  output logic [FILL_W-1:0]      out_fill_level
);

  brb_cmd_t    cmd;
  brb_status_t status;

  brb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  brb_datapath #(
    .DEPTH       (DEPTH),
    .MAX_REQUEST (MAX_REQUEST)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_action      (in_action),
    .in_data_in     (in_data_in),
    .in_length      (in_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_out   (out_data_out),
    .out_data_valid (out_data_valid),
    .out_done_count (out_done_count),
    .out_last       (out_last),
    .out_fill_level (out_fill_level)
  );

  a_cmd_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take_write, cmd.take_single, cmd.take_stream, cmd.rd_issue,
              cmd.load_byte}))
    else $error("more than one datapath command in a cycle");

  a_load_when_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_byte |-> status.out_free)
    else $error("byte loaded over an untaken result");

  a_issue_then_load : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |=> !cmd.rd_issue && !in_ready)
    else $error("byte read not followed by its load wait");

  a_status_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data_valid) |-> out_last)
    else $error("status result not marked last");

endmodule

`default_nettype wire
